### hdl/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg: shared definitions for the k-means clustering engine
// Register indexes, request codes, cell command types and controller states.
// ----------------------------------------------------------------------------
package kmc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned NP_W       = 13;
  localparam int unsigned ND_W       = 6;
  localparam int unsigned NK_W       = 6;
  localparam int unsigned MI_W       = 8;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 2'd3;

  localparam logic [NP_W-1:0] NP_RST = 13'd2;
  localparam logic [ND_W-1:0] ND_RST = 6'd5;
  localparam logic [NK_W-1:0] NK_RST = 6'd5;
  localparam logic [MI_W-1:0] MI_RST = 8'd50;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_SEED = 2'd1;
  localparam logic [1:0] REQ_RUN  = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  localparam logic RES_RUN   = 1'b0;
  localparam logic RES_LABEL = 1'b1;

  // memory-fed cell operation, applied in the cycle after the read
  typedef enum logic [1:0] {
    MOP_NONE,
    MOP_SEED,
    MOP_DIST,
    MOP_SUM
  } kmc_mop_e;

  typedef struct packed {
    logic clr_dist;
    logic shift;
    logic clr_sum;
    logic cnt_inc;
    logic div_go;
  } kmc_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RUN_INIT,
    ST_SEED,
    ST_PASS_INIT,
    ST_PT_START,
    ST_DIST,
    ST_DRAIN,
    ST_SCAN,
    ST_LBL_WR,
    ST_PASS_END,
    ST_UPD_CLR,
    ST_UPD_PT,
    ST_UPD_CNT,
    ST_UPD_DIM,
    ST_DIV_INIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } kmc_state_e;

endpackage

### hdl/kmc_cell.sv
// ----------------------------------------------------------------------------
// kmc_cell: one centroid cell of the k-means chain
// Holds a centroid, its coordinate sums and member count; accumulates the
// squared distance to the broadcast point, shifts it down the chain for the
// minimum scan, and divides sums by the count one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kmc_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned MAX_DIMS   = 32,
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned DIM_W      = 5,
  parameter int unsigned CL_W       = 5,
  parameter int unsigned CNT_W      = 13,
  parameter int unsigned SUM_W      = 28,
  parameter int unsigned DIST_W     = 39
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kmc_pkg::kmc_mop_e            mop_i,
  input  logic [CL_W-1:0]              msel_i,
  input  logic [DIM_W-1:0]             mdim_i,
  input  logic signed [VALUE_BITS-1:0] mdata_i,
  input  kmc_pkg::kmc_ctl_t            ctl_i,
  input  logic [CL_W-1:0]              csel_i,
  input  logic [DIM_W-1:0]             cdim_i,
  input  logic [DIST_W-1:0]            dist_i,
  output logic [DIST_W-1:0]            dist_o
);

  localparam int unsigned KW = $clog2(SUM_W + 1);

  logic signed [VALUE_BITS-1:0] cent_q [MAX_DIMS];
  logic signed [SUM_W-1:0]      sum_q  [MAX_DIMS];
  logic [CNT_W-1:0]             cnt_q;
  logic [2*VALUE_BITS:0]        prod_q;
  logic                         prod_v_q;
  logic [DIST_W-1:0]            dist_q;

  logic                         dv_busy_q;
  logic [KW-1:0]                dv_k_q;
  logic                         dv_neg_q;
  logic [SUM_W-1:0]             dv_a_q;
  logic [CNT_W-1:0]             dv_r_q;
  logic [DIM_W-1:0]             dv_dim_q;

  logic                         sel_m, sel_c;
  logic signed [VALUE_BITS:0]   diff;
  logic signed [2*VALUE_BITS+1:0] sq;
  logic signed [SUM_W-1:0]      sum_sel;
  logic [SUM_W-1:0]             mag;
  logic [CNT_W:0]               r_sh, r_nx;
  logic                         ge;
  logic [SUM_W-1:0]             q_nx;
  logic [VALUE_BITS-1:0]        q_res;
  logic                         dv_last;

  assign sel_m   = (msel_i == CL_W'(IDX));
  assign sel_c   = (csel_i == CL_W'(IDX));
  assign diff    = (VALUE_BITS+1)'(mdata_i) - (VALUE_BITS+1)'(cent_q[mdim_i]);
  assign sq      = diff * diff;
  assign sum_sel = sum_q[cdim_i];
  assign mag     = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

  // restoring divide step on magnitudes
  assign r_sh    = {dv_r_q, dv_a_q[SUM_W-1]};
  assign ge      = (r_sh >= {1'b0, cnt_q});
  assign r_nx    = ge ? (r_sh - {1'b0, cnt_q}) : r_sh;
  assign q_nx    = {dv_a_q[SUM_W-2:0], ge};
  assign dv_last = dv_busy_q && (dv_k_q == KW'(1));

  always_comb begin
    if (cnt_q == '0) begin
      q_res = '0;
    end else if (dv_neg_q) begin
      q_res = VALUE_BITS'(-q_nx);
    end else begin
      q_res = q_nx[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q  <= 1'b0;
      dv_busy_q <= 1'b0;
      dv_k_q    <= '0;
      cnt_q     <= '0;
    end else begin
      prod_v_q <= (mop_i == kmc_pkg::MOP_DIST);
      if (ctl_i.clr_sum) begin
        cnt_q <= '0;
      end else if (ctl_i.cnt_inc && sel_c) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (ctl_i.div_go) begin
        dv_busy_q <= 1'b1;
        dv_k_q    <= KW'(SUM_W);
      end else if (dv_busy_q) begin
        dv_k_q <= dv_k_q - KW'(1);
        if (dv_last) begin
          dv_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= sq[2*VALUE_BITS:0];
    if (ctl_i.clr_dist) begin
      dist_q <= '0;
    end else if (ctl_i.shift) begin
      dist_q <= dist_i;
    end else if (prod_v_q) begin
      dist_q <= dist_q + DIST_W'(prod_q);
    end
    if (mop_i == kmc_pkg::MOP_SEED && sel_m) begin
      cent_q[mdim_i] <= mdata_i;
    end else if (dv_last) begin
      cent_q[dv_dim_q] <= q_res;
    end
    if (ctl_i.clr_sum) begin
      for (int unsigned j = 0; j < MAX_DIMS; j++) begin
        sum_q[j] <= '0;
      end
    end else if (mop_i == kmc_pkg::MOP_SUM && sel_m) begin
      sum_q[mdim_i] <= sum_q[mdim_i] + SUM_W'(mdata_i);
    end
    if (ctl_i.div_go) begin
      dv_a_q   <= mag;
      dv_r_q   <= '0;
      dv_neg_q <= sum_sel[SUM_W-1];
      dv_dim_q <= cdim_i;
    end else if (dv_busy_q) begin
      dv_a_q <= q_nx;
      dv_r_q <= r_nx[CNT_W-1:0];
    end
  end

  assign dist_o = dist_q;

endmodule

### hdl/kmeans_clustering.sv
// ----------------------------------------------------------------------------
// kmeans_clustering: Lloyd k-means engine with a chain of centroid cells
// Load and seed items give no result. A label read gives its result strobe
// through the q_pend_q and res_v_q registers; reads may follow back to back.
// A run keeps busy_o high until it finishes; its length is set by the single
// embedding read port and the bit-serial dividers in each cell, and its
// result strobes in the first cycle with busy_o low. Results cannot be
// stalled.
// After reset the registers hold their defaults and every label reads zero;
// embedding and seed contents are undefined until loaded.
// ----------------------------------------------------------------------------
module kmeans_clustering #(
  parameter int unsigned MAX_POINTS   = 4096,
  parameter int unsigned MAX_DIMS     = 32,
  parameter int unsigned MAX_CLUSTERS = 32,
  parameter int unsigned VALUE_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [1:0]                            req_type_i,
  input  logic [$clog2(MAX_POINTS)-1:0]         point_index_i,
  input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] dim_index_i,
  input  logic [$clog2(MAX_CLUSTERS)-1:0]       cluster_index_i,
  input  logic signed [VALUE_BITS-1:0]          coord_value_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [kmc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic                                  result_valid_o,
  output logic                                  result_kind_o,
  output logic [$clog2(MAX_CLUSTERS)-1:0]       cluster_label_o,
  output logic [kmc_pkg::MI_W-1:0]              iterations_done_o,
  output logic                                  converged_o
);

  localparam int unsigned PT_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int unsigned DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned DC_W      = $clog2(MAX_DIMS + 1);
  localparam int unsigned CL_W      = $clog2(MAX_CLUSTERS);
  localparam int unsigned KC_W      = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned SUM_W     = VALUE_BITS + PT_W;
  localparam int unsigned DIST_W    = 2 * VALUE_BITS + 1 + DC_W;
  localparam int unsigned EMB_DEPTH = MAX_POINTS * (2 ** DIM_W);
  localparam int unsigned WAIT_W    = $clog2(SUM_W + 1);
  localparam int unsigned MI_W      = kmc_pkg::MI_W;

  // configuration
  logic [kmc_pkg::NP_W-1:0] np_q;
  logic [kmc_pkg::ND_W-1:0] nd_q;
  logic [kmc_pkg::NK_W-1:0] nk_q;
  logic [MI_W-1:0]          mi_q;
  logic [CNT_W-1:0]         n_c;
  logic [DC_W-1:0]          d_c;
  logic [KC_W-1:0]          k_c;

  // control
  kmc_pkg::kmc_state_e state_q, state_d;
  logic [PT_W-1:0]     i_q;
  logic [DIM_W-1:0]    j_q;
  logic [CL_W-1:0]     c_q;
  logic [CL_W-1:0]     s_q;
  logic [WAIT_W-1:0]   w_q;
  logic [MI_W-1:0]     passes_q;
  logic                conv_q, chg_q, first_q;
  logic [CNT_W-1:0]    lbl_n_q;
  logic [DIST_W-1:0]   best_q;
  logic [CL_W-1:0]     bc_q;
  logic                i_last, j_last, c_last, s_last;
  logic                accept;

  // memories and seeds
  logic signed [VALUE_BITS-1:0] emb_mem [EMB_DEPTH];
  logic signed [VALUE_BITS-1:0] emb_rdata_q;
  logic [PT_W+DIM_W-1:0]        emb_raddr;
  logic                         emb_we;
  logic [CL_W-1:0]              lbl_mem [MAX_POINTS];
  logic [CL_W-1:0]              lbl_rdata_q;
  logic [PT_W-1:0]              lbl_raddr;
  logic                         lbl_we;
  logic [PT_W-1:0]              seed_q [MAX_CLUSTERS];
  logic                         seed_oob;

  // cell command path
  kmc_pkg::kmc_mop_e   tag_mop_d, tag_mop_q;
  logic [CL_W-1:0]     tag_sel_d, tag_sel_q;
  logic [DIM_W-1:0]    tag_dim_q;
  logic                tag_zero_d, tag_zero_q;
  logic signed [VALUE_BITS-1:0] mdata;
  kmc_pkg::kmc_ctl_t   ctl;
  logic [DIST_W-1:0]   dist_w [MAX_CLUSTERS+1];

  // results
  logic                q_pend_q, q_ok_q;
  logic                res_v_q, res_kind_q, res_conv_q;
  logic [CL_W-1:0]     res_label_q;
  logic [MI_W-1:0]     res_iter_q;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != kmc_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    n_c = (32'(np_q) > MAX_POINTS)   ? CNT_W'(MAX_POINTS)   : CNT_W'(np_q);
    d_c = (32'(nd_q) > MAX_DIMS)     ? DC_W'(MAX_DIMS)      : DC_W'(nd_q);
    k_c = (32'(nk_q) > MAX_CLUSTERS) ? KC_W'(MAX_CLUSTERS)  : KC_W'(nk_q);
  end

  assign i_last   = (CNT_W'(i_q) == n_c - CNT_W'(1));
  assign j_last   = (DC_W'(j_q) == d_c - DC_W'(1));
  assign c_last   = (KC_W'(c_q) == k_c - KC_W'(1));
  assign s_last   = (KC_W'(s_q) == k_c - KC_W'(1));
  assign seed_oob = (32'(seed_q[c_q]) >= MAX_POINTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q <= kmc_pkg::NP_RST;
      nd_q <= kmc_pkg::ND_RST;
      nk_q <= kmc_pkg::NK_RST;
      mi_q <= kmc_pkg::MI_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        kmc_pkg::REG_NUM_POINTS:   np_q <= cfg_data_i[kmc_pkg::NP_W-1:0];
        kmc_pkg::REG_NUM_DIMS:     nd_q <= cfg_data_i[kmc_pkg::ND_W-1:0];
        kmc_pkg::REG_NUM_CLUSTERS: nk_q <= cfg_data_i[kmc_pkg::NK_W-1:0];
        kmc_pkg::REG_MAX_ITER:     mi_q <= cfg_data_i[MI_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kmc_pkg::ST_IDLE: begin
        if (accept && req_type_i == kmc_pkg::REQ_RUN) state_d = kmc_pkg::ST_RUN_INIT;
      end
      kmc_pkg::ST_RUN_INIT: begin
        if (mi_q == '0) state_d = kmc_pkg::ST_DONE;
        else if (k_c == '0 || d_c == '0) state_d = kmc_pkg::ST_PASS_INIT;
        else state_d = kmc_pkg::ST_SEED;
      end
      kmc_pkg::ST_SEED: begin
        if (j_last && c_last) state_d = kmc_pkg::ST_PASS_INIT;
      end
      kmc_pkg::ST_PASS_INIT: begin
        state_d = (n_c == '0) ? kmc_pkg::ST_PASS_END : kmc_pkg::ST_PT_START;
      end
      kmc_pkg::ST_PT_START: begin
        state_d = (d_c == '0) ? kmc_pkg::ST_DRAIN : kmc_pkg::ST_DIST;
      end
      kmc_pkg::ST_DIST: begin
        if (j_last) state_d = kmc_pkg::ST_DRAIN;
      end
      kmc_pkg::ST_DRAIN: begin
        if (w_q == WAIT_W'(1)) begin
          state_d = (k_c == '0) ? kmc_pkg::ST_LBL_WR : kmc_pkg::ST_SCAN;
        end
      end
      kmc_pkg::ST_SCAN: begin
        if (s_last) state_d = kmc_pkg::ST_LBL_WR;
      end
      kmc_pkg::ST_LBL_WR: begin
        state_d = i_last ? kmc_pkg::ST_PASS_END : kmc_pkg::ST_PT_START;
      end
      kmc_pkg::ST_PASS_END: begin
        if (!chg_q || (passes_q + MI_W'(1) == mi_q)) state_d = kmc_pkg::ST_DONE;
        else state_d = kmc_pkg::ST_UPD_CLR;
      end
      kmc_pkg::ST_UPD_CLR: begin
        state_d = (n_c == '0) ? kmc_pkg::ST_DIV_INIT : kmc_pkg::ST_UPD_PT;
      end
      kmc_pkg::ST_UPD_PT: state_d = kmc_pkg::ST_UPD_CNT;
      kmc_pkg::ST_UPD_CNT: begin
        if (d_c != '0) state_d = kmc_pkg::ST_UPD_DIM;
        else state_d = i_last ? kmc_pkg::ST_DIV_INIT : kmc_pkg::ST_UPD_PT;
      end
      kmc_pkg::ST_UPD_DIM: begin
        if (j_last) state_d = i_last ? kmc_pkg::ST_DIV_INIT : kmc_pkg::ST_UPD_PT;
      end
      kmc_pkg::ST_DIV_INIT: begin
        state_d = (d_c == '0) ? kmc_pkg::ST_PASS_INIT : kmc_pkg::ST_DIV_GO;
      end
      kmc_pkg::ST_DIV_GO: state_d = kmc_pkg::ST_DIV_WAIT;
      kmc_pkg::ST_DIV_WAIT: begin
        if (w_q == WAIT_W'(SUM_W - 1)) begin
          state_d = j_last ? kmc_pkg::ST_PASS_INIT : kmc_pkg::ST_DIV_GO;
        end
      end
      kmc_pkg::ST_DONE: state_d = kmc_pkg::ST_IDLE;
      default: state_d = kmc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    emb_raddr  = {i_q, j_q};
    lbl_raddr  = i_q;
    lbl_we     = 1'b0;
    tag_mop_d  = kmc_pkg::MOP_NONE;
    tag_sel_d  = c_q;
    tag_zero_d = 1'b0;
    ctl        = '0;
    unique case (state_q)
      kmc_pkg::ST_IDLE:     lbl_raddr = point_index_i;
      kmc_pkg::ST_SEED: begin
        emb_raddr  = {seed_q[c_q], j_q};
        tag_mop_d  = kmc_pkg::MOP_SEED;
        tag_zero_d = seed_oob;
      end
      kmc_pkg::ST_PT_START: ctl.clr_dist = 1'b1;
      kmc_pkg::ST_DIST:     tag_mop_d = kmc_pkg::MOP_DIST;
      kmc_pkg::ST_SCAN:     ctl.shift = 1'b1;
      kmc_pkg::ST_LBL_WR:   lbl_we = 1'b1;
      kmc_pkg::ST_UPD_CLR:  ctl.clr_sum = 1'b1;
      kmc_pkg::ST_UPD_CNT:  ctl.cnt_inc = 1'b1;
      kmc_pkg::ST_UPD_DIM: begin
        tag_mop_d = kmc_pkg::MOP_SUM;
        tag_sel_d = lbl_rdata_q;
      end
      kmc_pkg::ST_DIV_GO:   ctl.div_go = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kmc_pkg::ST_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      c_q       <= '0;
      s_q       <= '0;
      w_q       <= '0;
      passes_q  <= '0;
      conv_q    <= 1'b0;
      chg_q     <= 1'b0;
      first_q   <= 1'b1;
      lbl_n_q   <= '0;
      bc_q      <= '0;
      tag_mop_q <= kmc_pkg::MOP_NONE;
    end else begin
      state_q   <= state_d;
      tag_mop_q <= tag_mop_d;
      unique case (state_q)
        kmc_pkg::ST_RUN_INIT: begin
          passes_q <= '0;
          conv_q   <= 1'b0;
          lbl_n_q  <= '0;
          first_q  <= 1'b1;
          c_q      <= '0;
          j_q      <= '0;
        end
        kmc_pkg::ST_SEED: begin
          if (j_last) begin
            j_q <= '0;
            c_q <= c_q + CL_W'(1);
          end else begin
            j_q <= j_q + DIM_W'(1);
          end
        end
        kmc_pkg::ST_PASS_INIT: begin
          i_q   <= '0;
          chg_q <= 1'b0;
        end
        kmc_pkg::ST_PT_START: begin
          j_q  <= '0;
          bc_q <= '0;
          s_q  <= '0;
          w_q  <= '0;
        end
        kmc_pkg::ST_DIST:  j_q <= j_q + DIM_W'(1);
        kmc_pkg::ST_DRAIN: w_q <= w_q + WAIT_W'(1);
        kmc_pkg::ST_SCAN: begin
          // strict compare keeps the lowest index on ties
          if (s_q == '0 || dist_w[0] < best_q) bc_q <= s_q;
          s_q <= s_q + CL_W'(1);
        end
        kmc_pkg::ST_LBL_WR: begin
          if (bc_q != (first_q ? CL_W'(0) : lbl_rdata_q)) chg_q <= 1'b1;
          i_q <= i_q + PT_W'(1);
        end
        kmc_pkg::ST_PASS_END: begin
          passes_q <= passes_q + MI_W'(1);
          lbl_n_q  <= n_c;
          first_q  <= 1'b0;
          if (!chg_q) conv_q <= 1'b1;
        end
        kmc_pkg::ST_UPD_CLR: i_q <= '0;
        kmc_pkg::ST_UPD_CNT: begin
          j_q <= '0;
          if (d_c == '0) i_q <= i_q + PT_W'(1);
        end
        kmc_pkg::ST_UPD_DIM: begin
          if (j_last) i_q <= i_q + PT_W'(1);
          else j_q <= j_q + DIM_W'(1);
        end
        kmc_pkg::ST_DIV_INIT: j_q <= '0;
        kmc_pkg::ST_DIV_GO:   w_q <= '0;
        kmc_pkg::ST_DIV_WAIT: begin
          w_q <= w_q + WAIT_W'(1);
          if (w_q == WAIT_W'(SUM_W - 1)) j_q <= j_q + DIM_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    tag_sel_q  <= tag_sel_d;
    tag_dim_q  <= j_q;
    tag_zero_q <= tag_zero_d;
    if (state_q == kmc_pkg::ST_SCAN && (s_q == '0 || dist_w[0] < best_q)) begin
      best_q <= dist_w[0];
    end
  end

  // embedding store
  assign emb_we = accept && (req_type_i == kmc_pkg::REQ_LOAD)
                  && (32'(point_index_i) < MAX_POINTS) && (32'(dim_index_i) < MAX_DIMS);

  always_ff @(posedge clk_i) begin
    if (emb_we) emb_mem[{point_index_i, dim_index_i}] <= coord_value_i;
  end

  always_ff @(posedge clk_i) begin
    emb_rdata_q <= emb_mem[emb_raddr];
  end

  // label store
  always_ff @(posedge clk_i) begin
    if (lbl_we) lbl_mem[i_q] <= bc_q;
  end

  always_ff @(posedge clk_i) begin
    lbl_rdata_q <= lbl_mem[lbl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == kmc_pkg::REQ_SEED && 32'(cluster_index_i) < MAX_CLUSTERS) begin
      seed_q[cluster_index_i] <= point_index_i;
    end
  end

  // centroid chain
  assign mdata = tag_zero_q ? '0 : emb_rdata_q;
  assign dist_w[MAX_CLUSTERS] = '0;

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    kmc_cell #(
      .IDX        (g),
      .MAX_DIMS   (MAX_DIMS),
      .VALUE_BITS (VALUE_BITS),
      .DIM_W      (DIM_W),
      .CL_W       (CL_W),
      .CNT_W      (CNT_W),
      .SUM_W      (SUM_W),
      .DIST_W     (DIST_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mop_i   (tag_mop_q),
      .msel_i  (tag_sel_q),
      .mdim_i  (tag_dim_q),
      .mdata_i (mdata),
      .ctl_i   (ctl),
      .csel_i  (lbl_rdata_q),
      .cdim_i  (j_q),
      .dist_i  (dist_w[g+1]),
      .dist_o  (dist_w[g])
    );
  end

  // results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_pend_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      q_pend_q <= accept && (req_type_i == kmc_pkg::REQ_READ);
      res_v_q  <= q_pend_q || (state_q == kmc_pkg::ST_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    q_ok_q <= (CNT_W'(point_index_i) < lbl_n_q);
    if (q_pend_q) begin
      res_kind_q  <= kmc_pkg::RES_LABEL;
      res_label_q <= q_ok_q ? lbl_rdata_q : '0;
      res_iter_q  <= '0;
      res_conv_q  <= 1'b0;
    end else if (state_q == kmc_pkg::ST_DONE) begin
      res_kind_q  <= kmc_pkg::RES_RUN;
      res_label_q <= '0;
      res_iter_q  <= passes_q;
      res_conv_q  <= conv_q;
    end
  end

  assign result_valid_o    = res_v_q;
  assign result_kind_o     = res_kind_q;
  assign cluster_label_o   = res_label_q;
  assign iterations_done_o = res_iter_q;
  assign converged_o       = res_conv_q;

  // checks
  a_run_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_kind_o == kmc_pkg::RES_RUN)
      |-> $past(state_q == kmc_pkg::ST_DONE))
    else $error("run result without finished run");

  a_label_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmc_pkg::ST_LBL_WR) && (k_c != '0) |-> (KC_W'(bc_q) < k_c))
    else $error("label outside active clusters");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_kind_o == kmc_pkg::RES_RUN) |-> (iterations_done_o <= mi_q))
    else $error("pass count above limit");

endmodule
